FILE: rtl/core/dlfe_pkg.sv
// ---------------------------------------------------------------------------
// dlfe_pkg: shared types and constants for the delayed linear fade envelope
// Widths, command codes, register indexes and the controller/datapath
// command and status structs.
// ---------------------------------------------------------------------------
`default_nettype none

package dlfe_pkg;

  // progress format
  localparam int FRAC_BITS = 12;
  localparam int PROG_W    = FRAC_BITS + 1;
  localparam logic [PROG_W-1:0] ONE = PROG_W'(1) << FRAC_BITS;

  // field widths
  localparam int MODE_W    = 3;
  localparam int MS_W      = 16;
  localparam int ELAPSED_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // begin-fade product and recovered elapsed time
  localparam int PROD_W  = PROG_W + MS_W;
  localparam int MULHI_W = PROD_W - FRAC_BITS;
  localparam int MULEL_W = MULHI_W + 1;

  // ramp divider step counter
  localparam int DIV_CNT_W = $clog2(FRAC_BITS);

  // command codes
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK      = 3'd0,
    MODE_BEGIN_OUT = 3'd1,
    MODE_BEGIN_IN  = 3'd2,
    MODE_STOP      = 3'd3,
    MODE_PAUSE     = 3'd4,
    MODE_RESUME    = 3'd5
  } mode_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_DELAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_DURATION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_DELAY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_DURATION  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DESTROY      = 3'd4;

  // register reset values
  localparam logic [MS_W-1:0] DURATION_RESET = 16'd3000;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic tick_add;
    logic mode_apply;
    logic mul;
    logic div_start;
    logic div_step;
    logic ramp_apply;
    logic ramp_full;
    logic result_write;
  } dlfe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              active;
    logic              paused;
    logic              past_delay;
    logic              ramp_full;
    logic              div_last;
  } dlfe_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/dlfe_cmd_if.sv
// ---------------------------------------------------------------------------
// dlfe_cmd_if: command channel
// Carries one command item: mode and elapsed milliseconds.
// ---------------------------------------------------------------------------
`default_nettype none

interface dlfe_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [dlfe_pkg::MODE_W-1:0]  mode;
  logic [dlfe_pkg::MS_W-1:0]    delta_ms;

  modport source (output valid, output mode, output delta_ms, input ready);
  modport sink   (input valid, input mode, input delta_ms, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dlfe_res_if.sv
// ---------------------------------------------------------------------------
// dlfe_res_if: result channel
// Carries one result item: progress and the fade flags after a command.
// ---------------------------------------------------------------------------
`default_nettype none

interface dlfe_res_if;
  logic                         valid;
  logic                         ready;
  logic [dlfe_pkg::PROG_W-1:0]  progress;
  logic                         fading_out;
  logic                         fading_in;
  logic                         paused;
  logic                         destroy_request;

  modport source (output valid, output progress, output fading_out, output fading_in,
                  output paused, output destroy_request, input ready);
  modport sink   (input valid, input progress, input fading_out, input fading_in,
                  input paused, input destroy_request, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dlfe_cfg_if.sv
// ---------------------------------------------------------------------------
// dlfe_cfg_if: configuration write channel
// Carries a register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface dlfe_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dlfe_pkg::CFG_IDX_W-1:0] index;
  logic [dlfe_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/delayed_linear_fade_envelope_top.sv
// ---------------------------------------------------------------------------
// delayed_linear_fade_envelope_top: delayed linear fade envelope
// Fade-out/fade-in progress envelope driven by tick, begin, stop, pause
// and resume commands, with one result item per command item.
// ---------------------------------------------------------------------------
// Each command item yields one result item with the Q12 progress and flags
// after the command. Commands are handled one at a time. A tick that moves
// the ramp runs the 12-step serial restoring divider, which forms
// (elapsed - delay) / duration, before its result is written. A tick that
// completes the ramp or is still inside the delay skips the divider. A tick
// while idle or paused goes straight to the result. A begin command during
// a fade uses one multiply to recover elapsed time. Other commands apply
// directly. A new item is taken the cycle after a result enters the output
// register, even if it is not yet read. A stalled output holds the
// controller once a second result is ready. Registers may be written only
// while no command is in progress.
`default_nettype none

module delayed_linear_fade_envelope_top (
  input wire logic clk,
  input wire logic rst,
  dlfe_cmd_if.sink   cmd,
  dlfe_res_if.source result,
  dlfe_cfg_if.sink   cfg
);
  import dlfe_pkg::*;

  dlfe_cmd_t  ctrl_cmd;
  dlfe_stat_t dp_stat;
  logic       cmd_ready;
  logic       res_valid;

  // registers accept a write every cycle
  assign cfg.ready    = 1'b1;
  assign cmd.ready    = cmd_ready;
  assign result.valid = res_valid;

  // sequencing
  dlfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd_ready),
    .out_valid (res_valid),
    .out_ready (result.ready),
    .cmd_o     (ctrl_cmd),
    .stat_i    (dp_stat)
  );

  // state and arithmetic
  dlfe_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd_i          (ctrl_cmd),
    .stat_o         (dp_stat),
    .in_mode        (cmd.mode),
    .in_delta_ms    (cmd.delta_ms),
    .cfg_valid      (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .res_progress   (result.progress),
    .res_fading_out (result.fading_out),
    .res_fading_in  (result.fading_in),
    .res_paused     (result.paused),
    .res_destroy    (result.destroy_request)
  );

endmodule

`default_nettype wire

FILE: rtl/core/dlfe_datapath.sv
// ---------------------------------------------------------------------------
// dlfe_datapath: fade envelope state and arithmetic
// Holds configuration, elapsed counter, progress and flags, the begin-fade
// multiplier, the serial ramp divider and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module dlfe_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire dlfe_pkg::dlfe_cmd_t            cmd_i,
  output dlfe_pkg::dlfe_stat_t                stat_o,
  input  wire logic [dlfe_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [dlfe_pkg::MS_W-1:0]      in_delta_ms,
  input  wire logic                           cfg_valid,
  input  wire logic [dlfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dlfe_pkg::CFG_DAT_W-1:0] cfg_data,
  output logic [dlfe_pkg::PROG_W-1:0]         res_progress,
  output logic                                res_fading_out,
  output logic                                res_fading_in,
  output logic                                res_paused,
  output logic                                res_destroy
);
  import dlfe_pkg::*;

  // configuration
  logic [MS_W-1:0] out_delay;
  logic [MS_W-1:0] out_duration;
  logic [MS_W-1:0] in_delay;
  logic [MS_W-1:0] in_duration;
  logic            destroy_after_out;

  // envelope state
  logic [ELAPSED_W-1:0] elapsed;
  logic [PROG_W-1:0]    progress_q;
  logic                 out_active;
  logic                 in_active;
  logic                 pause_flag;

  // latched item and per-item flags
  logic [MODE_W-1:0] mode_q;
  logic [MS_W-1:0]   delta_q;
  logic              destroy_q;

  // arithmetic registers
  logic [PROD_W-1:0]    prod;
  logic [MS_W-1:0]      rem;
  logic [FRAC_BITS-1:0] quot;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic                 active;
  logic [MS_W-1:0]      cur_delay;
  logic [MS_W-1:0]      cur_duration;
  logic [ELAPSED_W:0]   elapsed_sum;
  logic [ELAPSED_W-1:0] elapsed_sat;
  logic [ELAPSED_W:0]   ramp_end;
  logic [PROG_W-1:0]    mul_factor;
  logic [MS_W-1:0]      mul_duration;
  logic [MS_W-1:0]      mul_delay;
  logic [MULEL_W-1:0]   mul_elapsed;
  logic [MS_W:0]        rem_shift;
  logic                 rem_ge;
  logic [PROG_W-1:0]    ramp_frac;

  assign active = out_active || in_active;

  // parameters of the running fade
  assign cur_delay    = out_active ? out_delay : in_delay;
  assign cur_duration = out_active ? out_duration : in_duration;

  // saturating elapsed update
  assign elapsed_sum = {1'b0, elapsed} + {{(ELAPSED_W + 1 - MS_W){1'b0}}, delta_q};
  assign elapsed_sat = elapsed_sum[ELAPSED_W] ? {ELAPSED_W{1'b1}} : elapsed_sum[ELAPSED_W-1:0];

  // ramp is complete once elapsed reaches delay plus duration
  assign ramp_end = {{(ELAPSED_W + 1 - MS_W){1'b0}}, cur_delay}
                  + {{(ELAPSED_W + 1 - MS_W){1'b0}}, cur_duration};

  // status to controller
  always_comb begin
    stat_o.mode       = mode_q;
    stat_o.active     = active;
    stat_o.paused     = pause_flag;
    stat_o.past_delay = elapsed >= {{(ELAPSED_W - MS_W){1'b0}}, cur_delay};
    stat_o.ramp_full  = {1'b0, elapsed} >= ramp_end;
    stat_o.div_last   = div_cnt == DIV_CNT_W'(FRAC_BITS - 1);
  end

  // operands for working elapsed time back out of progress
  always_comb begin
    if (mode_t'(mode_q) == MODE_BEGIN_IN) begin
      mul_factor   = ONE - progress_q;
      mul_duration = in_duration;
      mul_delay    = in_delay;
    end else begin
      mul_factor   = progress_q;
      mul_duration = out_duration;
      mul_delay    = out_delay;
    end
  end

  assign mul_elapsed = {1'b0, prod[PROD_W-1:FRAC_BITS]} + {{(MULEL_W - MS_W){1'b0}}, mul_delay};

  // one restoring division step
  assign rem_shift = {rem, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, cur_duration};

  assign ramp_frac = cmd_i.ramp_full ? ONE : {1'b0, quot};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_delay         <= '0;
      out_duration      <= DURATION_RESET;
      in_delay          <= '0;
      in_duration       <= DURATION_RESET;
      destroy_after_out <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OUT_DELAY:    out_delay         <= cfg_data;
        CFG_OUT_DURATION: out_duration      <= cfg_data;
        CFG_IN_DELAY:     in_delay          <= cfg_data;
        CFG_IN_DURATION:  in_duration       <= cfg_data;
        CFG_DESTROY:      destroy_after_out <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // envelope state
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed    <= '0;
      progress_q <= '0;
      out_active <= 1'b0;
      in_active  <= 1'b0;
      pause_flag <= 1'b0;
      destroy_q  <= 1'b0;
    end else begin
      priority if (cmd_i.load) begin
        destroy_q <= 1'b0;
      end else if (cmd_i.tick_add) begin
        elapsed <= elapsed_sat;
      end else if (cmd_i.ramp_apply) begin
        if (out_active) begin
          progress_q <= ramp_frac;
          if (cmd_i.ramp_full) begin
            out_active <= 1'b0;
            destroy_q  <= destroy_after_out;
          end
        end else begin
          progress_q <= ONE - ramp_frac;
          if (cmd_i.ramp_full) begin
            in_active <= 1'b0;
          end
        end
      end else if (cmd_i.mode_apply) begin
        unique case (mode_t'(mode_q))
          MODE_BEGIN_OUT: begin
            elapsed    <= active ? {{(ELAPSED_W - MULEL_W){1'b0}}, mul_elapsed} : '0;
            out_active <= 1'b1;
            in_active  <= 1'b0;
            pause_flag <= 1'b0;
          end
          MODE_BEGIN_IN: begin
            if (active) begin
              elapsed <= {{(ELAPSED_W - MULEL_W){1'b0}}, mul_elapsed};
            end else begin
              elapsed    <= '0;
              progress_q <= ONE;
            end
            in_active  <= 1'b1;
            out_active <= 1'b0;
            pause_flag <= 1'b0;
          end
          MODE_STOP: begin
            out_active <= 1'b0;
            in_active  <= 1'b0;
            progress_q <= '0;
            elapsed    <= '0;
          end
          MODE_PAUSE: begin
            if (active) begin
              pause_flag <= 1'b1;
            end
          end
          MODE_RESUME: begin
            pause_flag <= 1'b0;
          end
          default: ;
        endcase
      end else begin
        destroy_q <= destroy_q;
      end
    end
  end

  // item latch, multiplier, divider and result register
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      mode_q  <= in_mode;
      delta_q <= in_delta_ms;
    end
    if (cmd_i.mul) begin
      prod <= PROD_W'(mul_factor * mul_duration);
    end
    if (cmd_i.div_start) begin
      rem     <= elapsed[MS_W-1:0] - cur_delay;
      quot    <= '0;
      div_cnt <= '0;
    end else if (cmd_i.div_step) begin
      rem     <= rem_ge ? MS_W'(rem_shift - {1'b0, cur_duration}) : rem_shift[MS_W-1:0];
      quot    <= {quot[FRAC_BITS-2:0], rem_ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd_i.result_write) begin
      res_progress   <= progress_q;
      res_fading_out <= out_active;
      res_fading_in  <= in_active;
      res_paused     <= pause_flag;
      res_destroy    <= destroy_q;
    end
  end

`ifndef SYNTHESIS
  // the two fades never run together
  a_single_fade: assert property (@(posedge clk) disable iff (rst)
    !(out_active && in_active))
    else $error("fade-out and fade-in active together");

  // progress never exceeds one
  a_progress_range: assert property (@(posedge clk) disable iff (rst)
    progress_q <= ONE)
    else $error("progress above one");

  // pause is only taken while a fade runs
  a_pause_active: assert property (@(posedge clk) disable iff (rst)
    $rose(pause_flag) |-> $past(out_active || in_active))
    else $error("pause set while idle");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/dlfe_ctrl.sv
// ---------------------------------------------------------------------------
// dlfe_ctrl: fade envelope controller
// Sequences each command item through the datapath and owns the result
// valid flag of the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module dlfe_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output dlfe_pkg::dlfe_cmd_t       cmd_o,
  input  wire dlfe_pkg::dlfe_stat_t stat_i
);
  import dlfe_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVAL  = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_FIN   = 7'b0010000,
    S_BEGIN = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready = state == S_IDLE;

  // next state and datapath commands
  always_comb begin
    cmd_o      = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        unique case (mode_t'(stat_i.mode))
          MODE_TICK: begin
            if (stat_i.active && !stat_i.paused) begin
              cmd_o.tick_add = 1'b1;
              state_next     = S_CMP;
            end else begin
              state_next = S_DONE;
            end
          end
          MODE_BEGIN_OUT, MODE_BEGIN_IN: begin
            if (stat_i.active) begin
              cmd_o.mul  = 1'b1;
              state_next = S_BEGIN;
            end else begin
              cmd_o.mode_apply = 1'b1;
              state_next       = S_DONE;
            end
          end
          default: begin
            cmd_o.mode_apply = 1'b1;
            state_next       = S_DONE;
          end
        endcase
      end
      S_CMP: begin
        priority if (!stat_i.past_delay) begin
          state_next = S_DONE;
        end else if (stat_i.ramp_full) begin
          cmd_o.ramp_apply = 1'b1;
          cmd_o.ramp_full  = 1'b1;
          state_next       = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_next      = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.ramp_apply = 1'b1;
        state_next       = S_DONE;
      end
      S_BEGIN: begin
        cmd_o.mode_apply = 1'b1;
        state_next       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd_o.result_write = 1'b1;
          state_next         = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    priority if (cmd_o.result_write) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd_o.result_write)
    else $error("result overwritten while stalled");

  // the divider runs until its last step, then finishes
  a_div_flow: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |=> state == S_DIV || state == S_FIN)
    else $error("divider left early");

  // a result appears only after an item completes
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result valid without a finished item");
`endif

endmodule

`default_nettype wire
